>>> rtl/i2cbb_pkg.sv
// Shared types, codes and helpers for the I2C bit-bang master.
package i2cbb_pkg;

    // Data buffer geometry (depth is a power of two)
    localparam int BUF_DEPTH = 32;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    // Item function codes
    localparam logic [1:0] F_TICK   = 2'd0;
    localparam logic [1:0] F_LOAD   = 2'd1;
    localparam logic [1:0] F_START  = 2'd2;
    localparam logic [1:0] F_RDBACK = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ADDR  = 2'd0;
    localparam logic [1:0] CFG_WCNT  = 2'd1;
    localparam logic [1:0] CFG_RCNT  = 2'd2;

    // Bus sequencer states
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_START   = 4'd1;
    localparam logic [3:0] PH_START2  = 4'd2;
    localparam logic [3:0] PH_ADDR    = 4'd3;
    localparam logic [3:0] PH_DATA    = 4'd4;
    localparam logic [3:0] PH_WBIT    = 4'd5;
    localparam logic [3:0] PH_READ    = 4'd6;
    localparam logic [3:0] PH_RBIT    = 4'd7;
    localparam logic [3:0] PH_RACK    = 4'd8;
    localparam logic [3:0] PH_WACK    = 4'd9;
    localparam logic [3:0] PH_WAIT    = 4'd10;
    localparam logic [3:0] PH_STOP    = 4'd11;
    localparam logic [3:0] PH_STOP2   = 4'd12;
    localparam logic [3:0] PH_RESTART = 4'd13;
    localparam logic [3:0] PH_STOP3   = 4'd14;

    // Gap lengths in ticks
    localparam logic [2:0] GAP_SLAVE_ACK  = 3'd4;
    localparam logic [2:0] GAP_MASTER_ACK = 3'd2;

    localparam logic [7:0] MASK_MSB = 8'h80;

    typedef struct packed {
        logic [3:0] phase;
        logic       clk_ph;
        logic [7:0] shift;
        logic [7:0] mask;
        logic [5:0] bpos;
        logic [5:0] wleft;
        logic [5:0] rleft;
        logic [2:0] gap;
        logic       nack;
        logic       restart;
        logic       scl;
        logic       sda_drv;
        logic       sda_lvl;
    } t_state;

    typedef struct packed {
        logic [6:0] addr;
        logic [5:0] wcnt;
        logic [5:0] rcnt;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    // Buffer slot of a byte position: wraps modulo the buffer depth
    function automatic logic [BUF_AW-1:0] buf_slot(input logic [7:0] pos);
        return pos[BUF_AW-1:0];
    endfunction

endpackage

>>> rtl/i2cbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2cbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/i2cbb_step.sv
// Next-state logic of the bus sequencer for one transaction.
module i2cbb_step
    import i2cbb_pkg::*;
(
    input  t_state     i_st,
    input  t_cfg       i_cfg,
    input  logic [1:0] i_func,
    input  logic       i_sda_in,
    input  logic [4:0] i_buf_index,
    input  logic [7:0] i_buf_value,
    input  logic [7:0] i_rd_data,
    output t_state     o_st,
    output t_wr        o_wr,
    output logic [7:0] o_read_value
);

    t_state     n_st;
    t_wr        n_wr;
    logic [7:0] sb;
    logic [7:0] bm;
    logic [5:0] bp;
    logic       cp;
    logic [5:0] bp_prev;

    assign cp      = i_st.clk_ph;
    assign bp_prev = i_st.bpos - 6'd1;

    always_comb begin
        n_st         = i_st;
        n_wr         = '0;
        o_read_value = 8'd0;
        sb           = i_st.shift;
        bm           = i_st.mask;
        bp           = i_st.bpos;

        unique case (i_func)
            F_TICK: begin
                // SCL follows the clock phase held on entry
                if (i_st.phase != PH_IDLE) begin
                    n_st.scl = cp;
                end
                unique case (i_st.phase)
                    PH_IDLE: begin
                    end
                    PH_START: begin
                        n_st.phase = PH_START2;
                    end
                    PH_START2: begin
                        n_st.sda_lvl = 1'b0;
                        n_st.sda_drv = 1'b1;
                        n_st.clk_ph  = 1'b0;
                        n_st.nack    = 1'b0;
                        n_st.phase   = PH_ADDR;
                    end
                    PH_ADDR, PH_DATA, PH_WBIT: begin
                        // Load the next byte, then shift it out MSB first
                        if (i_st.phase == PH_ADDR) begin
                            sb = {i_cfg.addr, 1'b0};
                            if (i_st.wleft != 6'd0) begin
                                n_st.restart = 1'b0;
                            end else begin
                                sb[0] = 1'b1;
                            end
                            bp = 6'd0;
                        end else if (i_st.phase == PH_DATA) begin
                            sb = i_rd_data;
                        end
                        if (i_st.phase != PH_WBIT) begin
                            n_st.phase   = PH_WBIT;
                            bm           = MASK_MSB;
                            n_st.sda_drv = 1'b1;
                        end
                        if (!cp) begin
                            n_st.sda_lvl = |(sb & bm);
                            bm           = bm >> 1;
                        end
                        if (bm == 8'd0 && cp) begin
                            // address byte does not count as a write
                            if (bp != 6'd0) begin
                                n_st.wleft = i_st.wleft - 6'd1;
                            end
                            bp         = bp + 6'd1;
                            n_st.phase = PH_RACK;
                        end
                        n_st.shift  = sb;
                        n_st.mask   = bm;
                        n_st.bpos   = bp;
                        n_st.clk_ph = ~cp;
                    end
                    PH_READ, PH_RBIT: begin
                        // Sample SDA on the high half, store the byte when full
                        if (i_st.phase == PH_READ) begin
                            n_st.sda_drv = 1'b0;
                            n_st.phase   = PH_RBIT;
                            bm           = MASK_MSB;
                            sb           = 8'd0;
                        end
                        if (cp) begin
                            if (i_sda_in) begin
                                sb = sb | bm;
                            end
                            bm = bm >> 1;
                            if (bm == 8'd0) begin
                                n_wr.en    = 1'b1;
                                n_wr.addr  = buf_slot({2'b00, bp_prev});
                                n_wr.data  = sb;
                                n_st.bpos  = i_st.bpos + 6'd1;
                                n_st.rleft = i_st.rleft - 6'd1;
                                n_st.phase = PH_WACK;
                            end
                        end
                        n_st.shift  = sb;
                        n_st.mask   = bm;
                        n_st.clk_ph = ~cp;
                    end
                    PH_RACK: begin
                        // Slave acknowledge slot
                        if (!cp) begin
                            n_st.sda_drv = 1'b0;
                        end else if (!i_sda_in) begin
                            if (i_st.wleft != 6'd0 || i_st.restart) begin
                                n_st.gap   = GAP_SLAVE_ACK;
                                n_st.phase = PH_WAIT;
                            end else begin
                                n_st.phase = PH_STOP;
                            end
                        end else begin
                            n_st.nack  = 1'b1;
                            n_st.phase = PH_STOP;
                        end
                        n_st.clk_ph = ~cp;
                    end
                    PH_WACK: begin
                        // Master ACK, or NACK on the last read byte
                        if (!cp) begin
                            n_st.sda_lvl = (i_st.rleft == 6'd0);
                            n_st.sda_drv = 1'b1;
                        end else if (i_st.rleft != 6'd0) begin
                            n_st.gap   = GAP_MASTER_ACK;
                            n_st.phase = PH_WAIT;
                        end else begin
                            n_st.phase = PH_STOP;
                        end
                        n_st.clk_ph = ~cp;
                    end
                    PH_WAIT: begin
                        if (i_st.gap != 3'd0) begin
                            n_st.gap = i_st.gap - 3'd1;
                        end else if (i_st.wleft != 6'd0) begin
                            n_st.phase = PH_DATA;
                        end else if (i_st.rleft != 6'd0) begin
                            n_st.phase = PH_READ;
                        end else begin
                            n_st.phase = PH_STOP;
                        end
                    end
                    PH_STOP: begin
                        if (i_st.rleft != 6'd0) begin
                            n_st.sda_lvl = 1'b0;
                            n_st.sda_drv = 1'b1;
                        end else begin
                            n_st.sda_drv = 1'b0;
                        end
                        if (cp) begin
                            n_st.phase = PH_STOP2;
                        end
                        n_st.clk_ph = 1'b1;
                    end
                    PH_STOP2: begin
                        // Either finish, or raise SDA for a repeated start
                        if (i_st.nack || i_st.rleft == 6'd0) begin
                            n_st.phase = PH_STOP3;
                        end else begin
                            n_st.sda_lvl = 1'b1;
                            n_st.sda_drv = 1'b1;
                            n_st.clk_ph  = ~cp;
                            if (!cp) begin
                                n_st.phase   = PH_RESTART;
                                n_st.restart = 1'b1;
                            end
                        end
                    end
                    PH_RESTART: begin
                        n_st.phase = PH_START2;
                    end
                    PH_STOP3: begin
                        n_st.sda_drv = 1'b0;
                        n_st.phase   = PH_IDLE;
                    end
                    default: begin
                        n_st.phase = PH_IDLE;
                    end
                endcase
            end
            F_LOAD: begin
                n_wr.en   = 1'b1;
                n_wr.addr = buf_slot({3'b000, i_buf_index});
                n_wr.data = i_buf_value;
            end
            F_START: begin
                // A start aborts any running transfer
                n_st.phase   = PH_START;
                n_st.clk_ph  = 1'b1;
                n_st.nack    = 1'b0;
                n_st.wleft   = i_cfg.wcnt;
                n_st.rleft   = i_cfg.rcnt;
                n_st.restart = (i_cfg.wcnt == 6'd0);
            end
            F_RDBACK: begin
                o_read_value = i_rd_data;
            end
            default: begin
            end
        endcase
    end

    assign o_st = n_st;
    assign o_wr = n_wr;

endmodule

>>> rtl/i2c_bitbang_master.sv
// Top level of the I2C bit-bang master: handshakes, state, buffer and result register.
// Accepted transactions wait in the input register; results are loaded into the result register.
// Throughput: one transaction per cycle unless results stall; the input register and the result
// register decouple the two channels, and the buffer RAM is read as the transaction is accepted.
// Reset (synchronous, active low) idles the sequencer, clears the configuration registers and
// empties both pipeline stages; the data buffer is not cleared and reads are valid once written.
module i2c_bitbang_master
    import i2cbb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic       i_sda_in,
    input  logic [4:0] i_buf_index,
    input  logic [7:0] i_buf_value,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_level,
    output logic       o_sda_drive,
    output logic       o_sda_level,
    output logic       o_busy_res,
    output logic       o_nacked,
    output logic [7:0] o_read_value
);

    t_cfg        r_cfg;
    t_state      r_st;
    t_state      n_st;
    t_state      step_st;
    t_wr         step_wr;
    t_wr         wr_eff;
    logic [7:0]  step_rv;

    logic        r_in_vld;
    logic [1:0]  r_in_func;
    logic        r_in_sda;
    logic [4:0]  r_in_idx;
    logic [7:0]  r_in_val;

    logic        r_out_vld;
    logic        r_out_scl;
    logic        r_out_drv;
    logic        r_out_lvl;
    logic        r_out_busy;
    logic        r_out_nack;
    logic [7:0]  r_out_rv;

    logic        r_byp;
    logic [7:0]  r_byp_data;

    logic              proc;
    logic              acc;
    logic [BUF_AW-1:0] rd_addr;
    logic [5:0]        n_bpos_prev;
    logic [7:0]        ram_q;
    logic [7:0]        rd_data;
    logic              busy;

    // Handshake control
    assign proc       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || proc;
    assign acc        = i_in_valid && o_in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ADDR: r_cfg.addr <= i_cfg_data;
                CFG_WCNT: r_cfg.wcnt <= i_cfg_data[5:0];
                CFG_RCNT: r_cfg.rcnt <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (acc) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_in_func <= i_func;
            r_in_sda  <= i_sda_in;
            r_in_idx  <= i_buf_index;
            r_in_val  <= i_buf_value;
        end
    end

    // Sequencer step
    i2cbb_step u_step (
        .i_st         (r_st),
        .i_cfg        (r_cfg),
        .i_func       (r_in_func),
        .i_sda_in     (r_in_sda),
        .i_buf_index  (r_in_idx),
        .i_buf_value  (r_in_val),
        .i_rd_data    (rd_data),
        .o_st         (step_st),
        .o_wr         (step_wr),
        .o_read_value (step_rv)
    );

    assign n_st   = proc ? step_st : r_st;
    assign wr_eff = proc ? step_wr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{phase: PH_IDLE, scl: 1'b1, sda_lvl: 1'b1, default: '0};
        end else begin
            r_st <= n_st;
        end
    end

    // Buffer read: read-back index, or the byte a following data phase would load
    assign n_bpos_prev = n_st.bpos - 6'd1;
    assign rd_addr     = (i_func == F_RDBACK) ? buf_slot({3'b000, i_buf_index})
                                              : buf_slot({2'b00, n_bpos_prev});

    i2cbb_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (wr_eff.en),
        .i_waddr (wr_eff.addr),
        .i_wdata (wr_eff.data),
        .i_re    (acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Forward a write that lands on the address read in the same cycle
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_byp      <= wr_eff.en && (wr_eff.addr == rd_addr);
            r_byp_data <= wr_eff.data;
        end
    end

    assign rd_data = r_byp ? r_byp_data : ram_q;

    // Busy: on a tick it reflects the state before the step
    assign busy = (r_in_func == F_TICK) ? (r_st.phase != PH_IDLE)
                                        : (step_st.phase != PH_IDLE);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_scl  <= step_st.scl;
            r_out_drv  <= step_st.sda_drv;
            r_out_lvl  <= step_st.sda_lvl;
            r_out_busy <= busy;
            r_out_nack <= step_st.nack;
            r_out_rv   <= step_rv;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_scl_level  = r_out_scl;
    assign o_sda_drive  = r_out_drv;
    assign o_sda_level  = r_out_lvl;
    assign o_busy_res   = r_out_busy;
    assign o_nacked     = r_out_nack;
    assign o_read_value = r_out_rv;

    // Checks
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_func == F_START |=> o_out_valid && o_busy_res && !o_nacked)
        else $error("start transaction did not report busy");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    a_idle_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_func == F_TICK && r_st.phase == PH_STOP3 |=> !o_sda_drive)
        else $error("SDA still driven at end of transfer");

endmodule
